@@ rtl/rcpm_pkg.sv @@
// shared types, constants and sizes for the rms current power meter
package rcpm_pkg;

    // default sizes, also used as top level parameter defaults
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int OFFSET_SHIFT_DEF = 10;
    localparam int COUNT_BITS_DEF   = 16;

    // fixed arithmetic sizes
    localparam int FILTER_SHIFT = 10;
    localparam int SUM_BITS     = 64;
    localparam int ROOT_BITS    = SUM_BITS / 2;
    localparam int CLAMP_BITS   = 8;
    localparam int WINDOW_BITS  = 16;
    localparam int MV_BITS      = 12;
    localparam int VOLT_BITS    = 8;
    localparam int K_BITS       = CLAMP_BITS + MV_BITS;
    localparam int BASE_BITS    = K_BITS + ROOT_BITS;
    localparam int PWR_BITS     = BASE_BITS + VOLT_BITS;
    localparam int CUR_W        = 20;
    localparam int PWR_W        = 28;

    localparam logic [MV_BITS-1:0]   MV_FULL_SCALE = MV_BITS'(3300);
    localparam logic [VOLT_BITS-1:0] GRID_VOLTS    = VOLT_BITS'(230);
    localparam logic [63:0]          CUR_MAX       = 64'd1048575;
    localparam logic [63:0]          PWR_MAX       = 64'd268435455;

    // window queue between the front and back ends
    localparam int Q_DEPTH = 2;

    // configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SAMPLES = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLAMP_AMPS     = CFG_INDEX_BITS'(1);
    localparam logic [WINDOW_BITS-1:0]    WINDOW_RESET       = WINDOW_BITS'(1480);
    localparam logic [CLAMP_BITS-1:0]     CLAMP_RESET        = CLAMP_BITS'(100);

    typedef struct packed {
        logic [WINDOW_BITS-1:0] window_samples;
        logic [CLAMP_BITS-1:0]  clamp_full_scale_amps;
    } rcpm_cfg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_SQRT,
        B_MUL_BASE,
        B_MUL_PWR,
        B_OUT
    } rcpm_back_state_t;

endpackage

@@ rtl/rcpm_front.sv @@
// front end: offset tracking, squaring and window accumulation
module rcpm_front
    import rcpm_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int OFFSET_SHIFT = OFFSET_SHIFT_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   full,
    input  rcpm_cfg_t              cfg,
    output logic                   q_push,
    output logic [SUM_BITS-1:0]    q_sum,
    output logic [COUNT_BITS-1:0]  q_count,
    input  logic                   q_full
);

    localparam int W        = SAMPLE_BITS + OFFSET_SHIFT;
    localparam int CMP_BITS = (COUNT_BITS > WINDOW_BITS) ? COUNT_BITS : WINDOW_BITS;
    localparam logic [W-1:0] OFFSET_RESET = W'(1) << (W - 1);
    localparam logic [CMP_BITS-1:0] CNT_MAX = CMP_BITS'((64'd1 << COUNT_BITS) - 64'd1);

    logic [W-1:0]          offset_reg, offset_next;
    logic [W-1:0]          mag_reg;
    logic                  a_valid_reg;
    logic [2*W-1:0]        sq_reg;
    logic                  b_valid_reg;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  first_done_reg;

    logic                  advance;
    logic                  accept;
    logic [W-1:0]          s_fix;
    logic signed [W+1:0]   diff;
    logic signed [W+1:0]   step;
    logic signed [W+1:0]   off_sum;
    logic signed [W+1:0]   filt;
    logic [W+1:0]          filt_abs;
    logic [SUM_BITS:0]     sum_add;
    logic [CMP_BITS-1:0]   win;
    logic                  window_done;

    assign advance = !q_full;
    assign full    = q_full;
    assign accept  = push && advance;

    // offset moves toward the sample by the rounded difference over 1024
    always_comb
    begin
        s_fix       = {sample, {OFFSET_SHIFT{1'b0}}};
        diff        = $signed({2'b00, s_fix}) - $signed({2'b00, offset_reg});
        step        = (diff + $signed((W+2)'(1) << (FILTER_SHIFT - 1))) >>> FILTER_SHIFT;
        off_sum     = $signed({2'b00, offset_reg}) + step;
        offset_next = off_sum[W-1:0];
        filt        = $signed({2'b00, s_fix}) - $signed({2'b00, offset_next});
        filt_abs    = filt[W+1] ? (W+2)'(-filt) : filt;
    end

    // accumulate with saturation and window check
    always_comb
    begin
        sum_add     = {1'b0, sum_reg} + (SUM_BITS+1)'(sq_reg);
        count_next  = count_reg + COUNT_BITS'(1);
        win         = (cfg.window_samples == '0) ? CMP_BITS'(1)
                                                 : CMP_BITS'(cfg.window_samples);
        if (win > CNT_MAX)
        begin
            win = CNT_MAX;
        end
        window_done = b_valid_reg && (CMP_BITS'(count_next) >= win);
        sum_next    = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
        q_push      = advance && window_done && first_done_reg;
        q_sum       = sum_next;
        q_count     = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= OFFSET_RESET;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            sum_reg        <= '0;
            count_reg      <= '0;
            first_done_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= push;
            b_valid_reg <= a_valid_reg;
            if (accept)
            begin
                offset_reg <= offset_next;
            end
            if (b_valid_reg)
            begin
                if (window_done)
                begin
                    sum_reg        <= '0;
                    count_reg      <= '0;
                    first_done_reg <= 1'b1;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (accept)
            begin
                mag_reg <= filt_abs[W-1:0];
            end
            if (a_valid_reg)
            begin
                sq_reg <= mag_reg * mag_reg;
            end
        end
    end

endmodule

@@ rtl/rcpm_queue.sv @@
// short queue of finished window sums between front and back ends
module rcpm_queue
    import rcpm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [SUM_BITS-1:0]   wr_sum,
    input  logic [COUNT_BITS-1:0] wr_count,
    output logic                  q_full,
    input  logic                  rd_en,
    output logic                  q_empty,
    output logic [SUM_BITS-1:0]   rd_sum,
    output logic [COUNT_BITS-1:0] rd_count
);

    localparam int PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    logic [SUM_BITS-1:0]   sum_mem   [Q_DEPTH];
    logic [COUNT_BITS-1:0] count_mem [Q_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS:0]     fill_reg;

    assign q_full   = (fill_reg == (PTR_BITS+1)'(Q_DEPTH));
    assign q_empty  = (fill_reg == '0);
    assign rd_sum   = sum_mem[rd_ptr_reg];
    assign rd_count = count_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sum_mem[wr_ptr_reg]   <= wr_sum;
            count_mem[wr_ptr_reg] <= wr_count;
        end
    end

endmodule

@@ rtl/rcpm_back.sv @@
// back end: mean square divide, square root, scaling and result register
module rcpm_back
    import rcpm_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int OFFSET_SHIFT = OFFSET_SHIFT_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcpm_cfg_t             cfg,
    input  logic                  q_empty,
    input  logic [SUM_BITS-1:0]   q_sum,
    input  logic [COUNT_BITS-1:0] q_count,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [CUR_W-1:0]      current_ma,
    output logic [PWR_W-1:0]      power_mw
);

    localparam int SH        = SAMPLE_BITS + OFFSET_SHIFT;
    localparam int ITER_BITS = $clog2(SUM_BITS);
    localparam int SREM_BITS = ROOT_BITS + 2;
    localparam int CUR_FULL  = BASE_BITS - SH + 1;
    localparam int PWR_FULL  = PWR_BITS - SH + 1;

    rcpm_back_state_t state_reg, state_next;

    logic [ITER_BITS-1:0]  iter_reg;
    logic [SUM_BITS-1:0]   quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] div_reg;
    logic [SREM_BITS-1:0]  srem_reg;
    logic [ROOT_BITS-1:0]  root_reg;
    logic [K_BITS-1:0]     k_reg;
    logic [BASE_BITS-1:0]  base_reg;
    logic [PWR_BITS-1:0]   pwr_reg;
    logic                  res_valid_reg;
    logic [CUR_W-1:0]      cur_reg;
    logic [PWR_W-1:0]      pwrout_reg;

    logic                  iter_last;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  rem_ge;
    logic [SREM_BITS+1:0]  srem_sh;
    logic [SREM_BITS+1:0]  trial;
    logic                  srem_ge;
    logic [CUR_FULL-1:0]   cur_full;
    logic [PWR_FULL-1:0]   pwr_full;
    logic                  out_free;

    assign empty      = !res_valid_reg;
    assign current_ma = cur_reg;
    assign power_mw   = pwrout_reg;
    assign out_free   = !res_valid_reg || pop;

    // one quotient bit and one root bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[SUM_BITS-1]};
        rem_ge   = rem_sh >= {1'b0, div_reg};
        srem_sh  = {srem_reg, quo_reg[SUM_BITS-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        srem_ge  = srem_sh >= trial;
        cur_full = CUR_FULL'(base_reg >> SH) + CUR_FULL'(base_reg[SH-1]);
        pwr_full = PWR_FULL'(pwr_reg >> SH) + PWR_FULL'(pwr_reg[SH-1]);
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        iter_last  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                iter_last = (iter_reg == ITER_BITS'(SUM_BITS - 1));
                if (iter_last)
                begin
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                iter_last = (iter_reg == ITER_BITS'(ROOT_BITS - 1));
                if (iter_last)
                begin
                    state_next = B_MUL_BASE;
                end
            end
            B_MUL_BASE:
            begin
                state_next = B_MUL_PWR;
            end
            B_MUL_PWR:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            iter_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE || iter_last)
            begin
                iter_reg <= '0;
            end
            else
            begin
                iter_reg <= iter_reg + 1'b1;
            end
            if (state_reg == B_OUT && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                quo_reg <= q_sum;
                div_reg <= q_count;
                rem_reg <= '0;
                k_reg   <= cfg.clamp_full_scale_amps * MV_FULL_SCALE;
            end
            B_DIV:
            begin
                rem_reg <= rem_ge ? COUNT_BITS'(rem_sh - {1'b0, div_reg})
                                  : rem_sh[COUNT_BITS-1:0];
                quo_reg <= {quo_reg[SUM_BITS-2:0], rem_ge};
                // quotient is complete, hand it to the root unit
                if (iter_last)
                begin
                    srem_reg <= '0;
                    root_reg <= '0;
                end
            end
            B_SQRT:
            begin
                srem_reg <= srem_ge ? SREM_BITS'(srem_sh - trial) : SREM_BITS'(srem_sh);
                root_reg <= {root_reg[ROOT_BITS-2:0], srem_ge};
                quo_reg  <= {quo_reg[SUM_BITS-3:0], 2'b00};
            end
            B_MUL_BASE:
            begin
                base_reg <= k_reg * root_reg;
            end
            B_MUL_PWR:
            begin
                pwr_reg <= base_reg * GRID_VOLTS;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    cur_reg    <= (64'(cur_full) > CUR_MAX) ? CUR_W'(CUR_MAX)
                                                            : CUR_W'(cur_full);
                    pwrout_reg <= (64'(pwr_full) > PWR_MAX) ? PWR_W'(PWR_MAX)
                                                            : PWR_W'(pwr_full);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/rms_current_power_meter.sv @@
// top level of the rms current power meter
//
//  channel   ports                                      handshake
//  samples   push, full, sample                         push & !full
//  results   empty, pop, current_ma, power_mw           pop & !empty
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// one sample per clock is taken while full is low; it is squared and summed over three pipeline stages
// the window divide and root run in the back end once per window: 64 divide steps, 32 root steps,
// two multiplies and the result load
// full rises only while the two-entry window queue is full
// a pending result holds the back end in its last state, so samples stall once two
// more finished windows wait in the queue behind it
// reset sets the offset to mid-scale and clears sum, count and first-window flag;
// config returns to defaults
module rms_current_power_meter
    import rcpm_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int OFFSET_SHIFT = OFFSET_SHIFT_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [SAMPLE_BITS-1:0]    sample,
    output logic                      empty,
    input  logic                      pop,
    output logic [CUR_W-1:0]          current_ma,
    output logic [PWR_W-1:0]          power_mw,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    rcpm_cfg_t             cfg_reg;
    logic                  q_push;
    logic [SUM_BITS-1:0]   q_wr_sum;
    logic [COUNT_BITS-1:0] q_wr_count;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    logic [SUM_BITS-1:0]   q_rd_sum;
    logic [COUNT_BITS-1:0] q_rd_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_samples        <= WINDOW_RESET;
            cfg_reg.clamp_full_scale_amps <= CLAMP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_SAMPLES:
                begin
                    cfg_reg.window_samples <= cfg_data[WINDOW_BITS-1:0];
                end
                REG_CLAMP_AMPS:
                begin
                    cfg_reg.clamp_full_scale_amps <= cfg_data[CLAMP_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    rcpm_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .OFFSET_SHIFT (OFFSET_SHIFT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .sample  (sample),
        .full    (full),
        .cfg     (cfg_reg),
        .q_push  (q_push),
        .q_sum   (q_wr_sum),
        .q_count (q_wr_count),
        .q_full  (q_full)
    );

    rcpm_queue #(
        .COUNT_BITS (COUNT_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_sum   (q_wr_sum),
        .wr_count (q_wr_count),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .q_empty  (q_empty),
        .rd_sum   (q_rd_sum),
        .rd_count (q_rd_count)
    );

    rcpm_back #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .OFFSET_SHIFT (OFFSET_SHIFT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_sum      (q_rd_sum),
        .q_count    (q_rd_count),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .current_ma (current_ma),
        .power_mw   (power_mw)
    );

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the rms current power meter
module tb;
    import rcpm_pkg::*;

    localparam int SMP_W          = SAMPLE_BITS_DEF;
    localparam int OFS_W          = SAMPLE_BITS_DEF + OFFSET_SHIFT_DEF;
    localparam int SCALE_SH       = SAMPLE_BITS_DEF + OFFSET_SHIFT_DEF;
    localparam int SMP_MAX        = (1 << SMP_W) - 1;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int IDLE_PCT       = 37;
    localparam int MAX_SHOWN      = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED    = CFG_INDEX_BITS'(7);
    localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_TOP = CFG_INDEX_BITS'(15);

    typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {WAVE_UNIFORM, WAVE_NOISY, WAVE_RAILS, WAVE_FLAT} wave_t;

    typedef struct packed {
        logic [CUR_W-1:0] cur;
        logic [PWR_W-1:0] pwr;
    } reading_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
        logic [SMP_W-1:0]          smp;
        logic                      typed;
        reading_t                  rd;
    } stim_row_t;

    // typed readings only where the answer is obvious: zero offset error or zero clamp
    localparam stim_row_t DIR_ROWS [29] = '{
        '{ROW_CFG,    REG_WINDOW_SAMPLES, 16'd1,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd2048, 1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd2048, 1'b1, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd4095, 1'b0, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_CLAMP_AMPS,     16'hFFFF,  12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd4095, 1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_CLAMP_AMPS,     16'h0100,  12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd4095, 1'b1, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_WINDOW_SAMPLES, 16'd0,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd1234, 1'b1, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_CLAMP_AMPS,     16'd1,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_UNUSED,         16'hABCD,  12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_INDEX_TOP,      16'hFFFF,  12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_WINDOW_SAMPLES, 16'hFFFF,  12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd4095, 1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd4095, 1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd0,    1'b0, '{20'd0, 28'd0}},
        // window dropped below the count already reached
        '{ROW_CFG,    REG_WINDOW_SAMPLES, 16'd3,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd2048, 1'b0, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_CLAMP_AMPS,     16'd200,   12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_CFG,    REG_WINDOW_SAMPLES, 16'd2,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd4095, 1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd0,    1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd4095, 1'b0, '{20'd0, 28'd0}},
        '{ROW_SAMPLE, REG_WINDOW_SAMPLES, 16'd0,     12'd2048, 1'b0, '{20'd0, 28'd0}}
    };

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      push      = 1'b0;
    logic                      full;
    logic [SMP_W-1:0]          sample    = '0;
    logic                      empty;
    logic                      pop       = 1'b0;
    logic [CUR_W-1:0]          current_ma;
    logic [PWR_W-1:0]          power_mw;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // travels with each sample: a typed reading replaces the predicted one
    logic     row_typed   = 1'b0;
    reading_t row_reading = '0;

    logic steady     = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;
    int   idle_cycles = 0;
    int   mismatches  = 0;

    reading_t readings_due[$];

    // predictor state and register copies
    logic [OFS_W-1:0]          dc_offset   = OFS_W'(1) << (OFS_W - 1);
    logic [63:0]               energy_sum  = '0;
    logic [COUNT_BITS_DEF-1:0] window_fill = '0;
    logic                      warmed_up   = 1'b0;
    logic [WINDOW_BITS-1:0]    win_len     = WINDOW_RESET;
    logic [CLAMP_BITS-1:0]     clamp_amps  = CLAMP_RESET;

    rms_current_power_meter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .sample     (sample),
        .empty      (empty),
        .pop        (pop),
        .current_ma (current_ma),
        .power_mw   (power_mw),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [63:0] round_scale(input logic [63:0] num);
        return (num >> SCALE_SH) + ((num >> (SCALE_SH - 1)) & 64'd1);
    endfunction

    // one sample through offset tracking, window accumulation and end-of-window reading
    function automatic bit meter_step(input logic [SMP_W-1:0] smp, output reading_t rd);
        longint      s_fix;
        longint      drift;
        longint      filt;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] span;
        logic [63:0] base;
        logic [63:0] cur;
        logic [63:0] pwr;
        rd = '0;
        s_fix = longint'(smp) <<< OFFSET_SHIFT_DEF;
        drift = (s_fix - longint'(dc_offset) + (longint'(1) <<< (FILTER_SHIFT - 1)))
                >>> FILTER_SHIFT;
        dc_offset = OFS_W'(longint'(dc_offset) + drift);
        filt = s_fix - longint'(dc_offset);
        mag = (filt < 0) ? 64'(-filt) : 64'(filt);
        sq = mag * mag;
        energy_sum = (energy_sum > ~sq) ? '1 : energy_sum + sq;
        window_fill = window_fill + 1'b1;
        span = (win_len == '0) ? 64'd1 : 64'(win_len);
        if (64'(window_fill) < span)
            return 1'b0;
        base = 64'(clamp_amps) * 64'(MV_FULL_SCALE) * int_sqrt(energy_sum / 64'(window_fill));
        energy_sum = '0;
        window_fill = '0;
        if (!warmed_up)
        begin
            warmed_up = 1'b1;
            return 1'b0;
        end
        cur = round_scale(base);
        pwr = round_scale(base * 64'(GRID_VOLTS));
        rd.cur = (cur > CUR_MAX) ? CUR_MAX[CUR_W-1:0] : cur[CUR_W-1:0];
        rd.pwr = (pwr > PWR_MAX) ? PWR_MAX[PWR_W-1:0] : pwr[PWR_W-1:0];
        return 1'b1;
    endfunction

    function automatic void flag_error(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endfunction

    function automatic logic [SMP_W-1:0] wave_sample(input wave_t wave, input int centre,
                                                     input int amp);
        case (wave)
            WAVE_UNIFORM: return SMP_W'($urandom);
            WAVE_NOISY:   return SMP_W'(centre - amp + int'($urandom_range(0, 2 * amp)));
            WAVE_RAILS:   return $urandom_range(0, 1) ? SMP_W'(SMP_MAX) : '0;
            default:      return SMP_W'(centre);
        endcase
    endfunction

    always @(posedge clk)
    begin : scoreboard
        reading_t rd;
        reading_t want;
        bit       made;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WINDOW_SAMPLES)
                    win_len = cfg_data[WINDOW_BITS-1:0];
                else if (cfg_index == REG_CLAMP_AMPS)
                    clamp_amps = cfg_data[CLAMP_BITS-1:0];
            end
            if (push && !full)
            begin
                made = meter_step(sample, rd);
                if (row_typed)
                    readings_due.push_back(row_reading);
                else if (made)
                    readings_due.push_back(rd);
            end
            if (pop && !empty)
            begin
                if (readings_due.size() == 0)
                    flag_error("unexpected result, current_ma", '0, 64'(current_ma));
                else
                begin
                    want = readings_due.pop_front();
                    if (current_ma !== want.cur)
                        flag_error("current_ma", 64'(want.cur), 64'(current_ma));
                    if (power_mw !== want.pwr)
                        flag_error("power_mw", 64'(want.pwr), 64'(power_mw));
                end
            end
        end
    end

    // result side: random stalls (none while steady), one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
            pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rms_current_power_meter: mismatch");
            $finish;
        end
    end

    // wait until every reading has been taken and the back end has gone quiet
    task automatic settle();
        push <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] smp, input logic typed,
                               input reading_t rd);
        cfg_valid <= 1'b0;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        sample <= smp;
        row_typed <= typed;
        row_reading <= rd;
        do @(posedge clk); while (full);
    endtask

    initial
    begin : stimulus
        wave_t                    wave;
        int                       centre;
        int                       amp;
        int                       phase_len;
        int                       sent;
        int                       phase;
        logic [WINDOW_BITS-1:0]   win_pick;
        logic [CFG_DATA_BITS-1:0] clamp_data;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
                write_reg(DIR_ROWS[i].index, DIR_ROWS[i].data);
            else
                send_sample(DIR_ROWS[i].smp, DIR_ROWS[i].typed, DIR_ROWS[i].rd);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 15))
                0:       win_pick = '0;
                1:       win_pick = WINDOW_BITS'($urandom_range(100, 400));
                default: win_pick = WINDOW_BITS'($urandom_range(1, 20));
            endcase
            // one sample per window lets results back up during the hold-off
            if (phase == 1)
                win_pick = WINDOW_BITS'(1);
            clamp_data = CFG_DATA_BITS'($urandom);
            case ($urandom_range(0, 7))
                0:       clamp_data[CLAMP_BITS-1:0] = '1;
                1:       clamp_data[CLAMP_BITS-1:0] = CLAMP_BITS'(1);
                2:       clamp_data[CLAMP_BITS-1:0] = '0;
                default: ;
            endcase
            write_reg(REG_WINDOW_SAMPLES, CFG_DATA_BITS'(win_pick));
            write_reg(REG_CLAMP_AMPS, clamp_data);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_INDEX_BITS'($urandom_range(REG_CLAMP_AMPS + 1, REG_INDEX_TOP)),
                          CFG_DATA_BITS'($urandom));

            wave = wave_t'($urandom_range(0, 3));
            centre = $urandom_range(0, SMP_MAX);
            amp = $urandom_range(0, (centre < SMP_MAX - centre) ? centre : SMP_MAX - centre);
            phase_len = $urandom_range(30, 90);
            steady <= (phase == 2);
            if (phase == 1)
                hold_req <= 1'b1;
            if (phase == 2)
                phase_len = 150;

            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                send_sample(wave_sample(wave, centre, amp), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        settle();
        if (mismatches == 0 && readings_due.size() == 0)
            $display("rms_current_power_meter: match");
        else
            $display("rms_current_power_meter: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rcpm_pkg.sv
rtl/rcpm_front.sv
rtl/rcpm_queue.sv
rtl/rcpm_back.sv
rtl/rms_current_power_meter.sv
tb/sv/tb.sv
